// ===== sv/refcounted_block_free_list_core_macros.svh =====
// Assertion helpers used by the free list core RTL.
`ifndef REFCOUNTED_BLOCK_FREE_LIST_CORE_MACROS_SVH
`define REFCOUNTED_BLOCK_FREE_LIST_CORE_MACROS_SVH

// Check a property on every rising edge, quiet while reset is held.
`define RCBFL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("rcbfl assertion failed");

// Check that a condition never holds while out of reset.
`define RCBFL_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("rcbfl forbidden condition seen");

`endif

// ===== sv/rcbfl_pkg.sv =====
`default_nettype none
package rcbfl_pkg;
    localparam int POOL_BLOCKS = 1024;
    localparam int MAX_ALLOC  = 64;
    localparam int REF_BITS   = 16;
    localparam int ID_W       = 10;
    localparam int LINK_W     = 11;
    localparam int CNT_W      = 7;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = 2 * LINK_W + REF_BITS;

    localparam logic [LINK_W-1:0]   LINK_NULL = LINK_W'(POOL_BLOCKS);
    localparam logic [REF_BITS-1:0] REF_MAX   = {REF_BITS{1'b1}};
    localparam logic [CNT_W-1:0]    ALLOC_MAX = CNT_W'(MAX_ALLOC);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TOUCH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOFREE  = 3'd1,
        ST_BADID   = 3'd2,
        ST_NOTREF  = 3'd3,
        ST_SAT     = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef struct packed {
        logic [LINK_W-1:0]   nxt;
        logic [LINK_W-1:0]   prv;
        logic [REF_BITS-1:0] refc;
    } entry_t;
endpackage
`default_nettype wire

// ===== sv/rcbfl_ram.sv =====
`default_nettype none
module rcbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/refcounted_block_free_list_core.sv =====
// Reference-counted free list of cache blocks.
// Input channel s_*: one transaction is an op (allocate, free, touch) with a
// block id and an allocation count. Result channel m_*: result_block,
// status, last and the free count after the whole transaction.
// Allocate of N blocks gives N results (last on the final one) or one
// failure result; free and touch give one result; op 3 gives none.
// All per-block state (links, reference count) sits in one single-port-write
// RAM with a registered read; each block update is a read, modify and
// write on that RAM, one transaction at a time.
// Allocate reads the head entry, then for each block pops and emits it and
// rewrites the new head's link; free and touch read the block, then update
// neighbour links as needed; failures go straight to the emit step.
// Reset (aresetn low, synchronous) starts a clearing pass over all 1024
// entries that writes the initial id-ordered chain; s_ready stays low meanwhile.
// A result waits in the output register while m_ready is low; the engine
// holds at its next emit step until that register is taken.
`default_nettype none
module refcounted_block_free_list_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [rcbfl_pkg::OP_W-1:0]      s_op,
    input  wire logic [rcbfl_pkg::ID_W-1:0]      s_block_id,
    input  wire logic [rcbfl_pkg::CNT_W-1:0]     s_count,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [rcbfl_pkg::ID_W-1:0]      m_result_block,
    output logic      [rcbfl_pkg::STATUS_W-1:0]  m_status,
    output logic                                 m_last,
    output logic      [rcbfl_pkg::LINK_W-1:0]    m_free_count
);
    import rcbfl_pkg::*;
    `include "refcounted_block_free_list_core_macros.svh"

    typedef enum logic [10:0] {
        S_INIT   = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_A_RD   = 11'b00000000100,
        S_A_HAVE = 11'b00000001000,
        S_A_NEXT = 11'b00000010000,
        S_F_RD   = 11'b00000100000,
        S_F_TAIL = 11'b00001000000,
        S_T_RD   = 11'b00010000000,
        S_T_PREV = 11'b00100000000,
        S_T_NEXT = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ID_W-1:0]   init_cnt_reg, init_cnt_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] free_total_reg, free_total_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [ID_W-1:0]   blk_reg, blk_next;
    status_t           status_reg, status_next;
    entry_t            hd_reg, hd_next;
    logic [LINK_W-1:0] p_reg, p_next;
    logic [LINK_W-1:0] n_reg, n_next;

    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_blk_reg, m_blk_next;
    status_t           m_status_reg, m_status_next;
    logic              m_last_reg, m_last_next;
    logic [LINK_W-1:0] m_free_reg, m_free_next;

    logic              ram_we, ram_re;
    logic [ID_W-1:0]   ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    logic              in_acc, out_free;
    logic              idle_empty, emit_stalled;
    entry_t            e;

    assign ram_rdata = entry_t'(ram_rdata_raw);

    rcbfl_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_BLOCKS)) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_total_next = free_total_reg;
        rem_next        = rem_reg;
        id_next         = id_reg;
        blk_next        = blk_reg;
        status_next     = status_reg;
        hd_next         = hd_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_blk_next      = m_blk_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        m_free_next     = m_free_reg;
        ram_we          = 1'b0;
        ram_waddr       = id_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = id_reg;
        e               = ram_rdata;

        case (state_reg)
            S_INIT: begin
                // lay down the reset chain, one entry a cycle
                ram_we         = 1'b1;
                ram_waddr      = init_cnt_reg;
                ram_wdata.nxt  = LINK_W'(init_cnt_reg) + LINK_W'(1);
                ram_wdata.prv  = (init_cnt_reg == '0) ? LINK_NULL
                                 : LINK_W'(init_cnt_reg) - LINK_W'(1);
                ram_wdata.refc = '0;
                init_cnt_next  = init_cnt_reg + ID_W'(1);
                if (init_cnt_reg == ID_W'(POOL_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    id_next  = s_block_id;
                    blk_next = (op_t'(s_op) == OP_ALLOC) ? '0 : s_block_id;
                    case (op_t'(s_op))
                        OP_ALLOC: begin
                            if (s_count == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end else if (s_count > ALLOC_MAX ||
                                         LINK_W'(s_count) > free_total_reg) begin
                                status_next = ST_NOFREE;
                                state_next  = S_EMIT;
                            end else begin
                                free_total_next = free_total_reg - LINK_W'(s_count);
                                rem_next        = s_count;
                                ram_re          = 1'b1;
                                ram_raddr       = head_reg[ID_W-1:0];
                                state_next      = S_A_RD;
                            end
                        end
                        OP_FREE, OP_TOUCH: begin
                            if (LINK_W'(s_block_id) >= LINK_W'(POOL_BLOCKS)) begin
                                status_next = ST_BADID;
                                state_next  = S_EMIT;
                            end else begin
                                ram_re      = 1'b1;
                                ram_raddr   = s_block_id;
                                status_next = ST_OK;
                                state_next  = (op_t'(s_op) == OP_FREE) ? S_F_RD : S_T_RD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_A_RD: begin
                hd_next    = ram_rdata;
                state_next = S_A_HAVE;
            end
            S_A_HAVE: begin
                // pop the head block and emit it
                if (out_free) begin
                    ram_we         = 1'b1;
                    ram_waddr      = head_reg[ID_W-1:0];
                    ram_wdata.nxt  = LINK_NULL;
                    ram_wdata.prv  = LINK_NULL;
                    ram_wdata.refc = REF_BITS'(1);
                    m_valid_next   = 1'b1;
                    m_blk_next     = head_reg[ID_W-1:0];
                    m_status_next  = ST_OK;
                    m_last_next    = (rem_reg == CNT_W'(1));
                    m_free_next    = free_total_reg;
                    rem_next       = rem_reg - CNT_W'(1);
                    if (hd_reg.nxt != LINK_NULL) begin
                        ram_re     = 1'b1;
                        ram_raddr  = hd_reg.nxt[ID_W-1:0];
                        n_next     = hd_reg.nxt;
                        state_next = S_A_NEXT;
                    end else begin
                        head_next  = LINK_NULL;
                        tail_next  = LINK_NULL;
                        state_next = S_IDLE;
                    end
                end
            end
            S_A_NEXT: begin
                // new head loses its predecessor; keep its entry for the next pop
                e.prv     = LINK_NULL;
                ram_we    = 1'b1;
                ram_waddr = n_reg[ID_W-1:0];
                ram_wdata = e;
                hd_next   = e;
                head_next = n_reg;
                state_next = (rem_reg != '0) ? S_A_HAVE : S_IDLE;
            end
            S_F_RD: begin
                if (e.refc == '0) begin
                    status_next = ST_NOTREF;
                    state_next  = S_EMIT;
                end else if (e.refc == REF_BITS'(1)) begin
                    // last reference dropped: append at the tail
                    ram_we          = 1'b1;
                    ram_wdata.nxt   = LINK_NULL;
                    ram_wdata.prv   = tail_reg;
                    ram_wdata.refc  = '0;
                    p_next          = tail_reg;
                    tail_next       = LINK_W'(id_reg);
                    free_total_next = free_total_reg + LINK_W'(1);
                    if (tail_reg != LINK_NULL) begin
                        ram_re     = 1'b1;
                        ram_raddr  = tail_reg[ID_W-1:0];
                        state_next = S_F_TAIL;
                    end else begin
                        head_next  = LINK_W'(id_reg);
                        state_next = S_EMIT;
                    end
                end else begin
                    e.refc     = e.refc - REF_BITS'(1);
                    ram_we     = 1'b1;
                    ram_wdata  = e;
                    state_next = S_EMIT;
                end
            end
            S_F_TAIL: begin
                e.nxt      = LINK_W'(id_reg);
                ram_we     = 1'b1;
                ram_waddr  = p_reg[ID_W-1:0];
                ram_wdata  = e;
                state_next = S_EMIT;
            end
            S_T_RD: begin
                if (e.refc == '0) begin
                    // unlink from the free queue
                    p_next          = e.prv;
                    n_next          = e.nxt;
                    ram_we          = 1'b1;
                    ram_wdata.nxt   = LINK_NULL;
                    ram_wdata.prv   = LINK_NULL;
                    ram_wdata.refc  = REF_BITS'(1);
                    free_total_next = free_total_reg - LINK_W'(1);
                    if (e.prv != LINK_NULL) begin
                        ram_re     = 1'b1;
                        ram_raddr  = e.prv[ID_W-1:0];
                        state_next = S_T_PREV;
                    end else begin
                        head_next = e.nxt;
                        if (e.nxt != LINK_NULL) begin
                            ram_re     = 1'b1;
                            ram_raddr  = e.nxt[ID_W-1:0];
                            state_next = S_T_NEXT;
                        end else begin
                            tail_next  = e.prv;
                            state_next = S_EMIT;
                        end
                    end
                end else if (e.refc == REF_MAX) begin
                    status_next = ST_SAT;
                    state_next  = S_EMIT;
                end else begin
                    e.refc     = e.refc + REF_BITS'(1);
                    ram_we     = 1'b1;
                    ram_wdata  = e;
                    state_next = S_EMIT;
                end
            end
            S_T_PREV: begin
                e.nxt     = n_reg;
                ram_we    = 1'b1;
                ram_waddr = p_reg[ID_W-1:0];
                ram_wdata = e;
                if (n_reg != LINK_NULL) begin
                    ram_re     = 1'b1;
                    ram_raddr  = n_reg[ID_W-1:0];
                    state_next = S_T_NEXT;
                end else begin
                    tail_next  = p_reg;
                    state_next = S_EMIT;
                end
            end
            S_T_NEXT: begin
                e.prv      = p_reg;
                ram_we     = 1'b1;
                ram_waddr  = n_reg[ID_W-1:0];
                ram_wdata  = e;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_blk_next    = blk_reg;
                    m_status_next = status_reg;
                    m_last_next   = 1'b1;
                    m_free_next   = free_total_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            init_cnt_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= LINK_W'(POOL_BLOCKS - 1);
            free_total_reg <= LINK_W'(POOL_BLOCKS);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_total_reg <= free_total_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        id_reg       <= id_next;
        blk_reg      <= blk_next;
        status_reg   <= status_next;
        hd_reg       <= hd_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        m_blk_reg    <= m_blk_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        m_free_reg   <= m_free_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_block = m_blk_reg;
    assign m_status       = m_status_reg;
    assign m_last         = m_last_reg;
    assign m_free_count   = m_free_reg;

    assign idle_empty   = (state_reg == S_IDLE) && (free_total_reg == '0);
    assign emit_stalled = m_valid_reg && !m_ready && (state_reg == S_EMIT);

    `RCBFL_ASSERT(a_free_bound, free_total_reg <= LINK_W'(POOL_BLOCKS))
    `RCBFL_NEVER(a_ram_collide, ram_we && ram_re && (ram_waddr == ram_raddr))
    `RCBFL_ASSERT(a_empty_null, idle_empty |-> (head_reg == LINK_NULL && tail_reg == LINK_NULL))
    `RCBFL_ASSERT(a_emit_slot, emit_stalled |=> state_reg == S_EMIT)
endmodule
`default_nettype wire
